// ===== design/stp_pkg.sv =====
// Shared types, constants and helper functions for the stadium track point pipeline.
package stp_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int FRAC_BITS    = 4;
    localparam int LAP_W        = ANGLE_BITS;
    localparam int LANE_W       = 14;
    localparam int POS_W        = 18;
    localparam int RAD_W        = 11;
    localparam int LEN_W        = 12;
    localparam int CTR_W        = 12;
    localparam int FLAT_W       = 16;
    localparam int HEAD_W       = 16;
    localparam int ARC_W        = 17;
    localparam int TOTAL_W      = 19;
    localparam int S_W          = TOTAL_W + 1;
    localparam int PHI_W        = ANGLE_BITS - 1;
    localparam int CORDIC_STEPS = 14;
    localparam int XY_W         = 18;
    localparam int Z_W          = 17;
    localparam int RADQ_W       = 17;
    localparam int PROD_W       = LAP_W + TOTAL_W;
    localparam int SPROD_W      = RADQ_W + XY_W;
    localparam int PI_W         = 31;
    localparam int ARCP_W       = RAD_W + PI_W + FRAC_BITS;

    localparam logic [PI_W-1:0] PI_Q29      = 31'd1686629713;
    localparam logic [XY_W-1:0] CORDIC_GAIN = 18'd39797;
    localparam logic [LAP_W-1:0] LAP_SHIFT  = LAP_W'(3 << (ANGLE_BITS - 2));
    localparam logic [HEAD_W-1:0] HEAD_WEST = HEAD_W'(1 << (HEAD_W - 1));

    localparam logic [RAD_W-1:0]  RST_TURN_RADIUS     = 11'd200;
    localparam logic [LEN_W-1:0]  RST_STRAIGHT_LENGTH = 12'd400;
    localparam logic [CTR_W-1:0]  RST_CENTER_X        = 12'd640;
    localparam logic [CTR_W-1:0]  RST_CENTER_Y        = 12'd360;
    localparam logic [FLAT_W-1:0] RST_FLAT_RADIUS     = 16'd65535;

    typedef enum logic [2:0] {
        REG_TURN_RADIUS     = 3'd0,
        REG_STRAIGHT_LENGTH = 3'd1,
        REG_CENTER_X        = 3'd2,
        REG_CENTER_Y        = 3'd3,
        REG_FLAT_RADIUS     = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        SEG_BOTTOM = 2'd0,
        SEG_LEFT   = 2'd1,
        SEG_TOP    = 2'd2,
        SEG_RIGHT  = 2'd3
    } seg_t;

    typedef struct packed {
        logic [RAD_W-1:0]  turn_radius;
        logic [LEN_W-1:0]  straight_length;
        logic [CTR_W-1:0]  center_x;
        logic [CTR_W-1:0]  center_y;
        logic [FLAT_W-1:0] flat_radius;
        logic [ARC_W-1:0]  arc;
    } cfg_t;

    typedef struct packed {
        seg_t                     seg;
        logic signed [RADQ_W-1:0] rad;
        logic [POS_W-1:0]         px;
        logic [POS_W-1:0]         py;
        logic [FLAT_W-1:0]        crad;
    } side_t;

    typedef struct packed {
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [HEAD_W-1:0] heading;
        seg_t              seg;
        logic [FLAT_W-1:0] crad;
    } res_t;

    // Turn arc length with FRAC_BITS fraction bits, rounded.
    function automatic logic [ARC_W-1:0] arc_of(input logic [RAD_W-1:0] r);
        logic [ARCP_W-1:0] p;
        p = ARCP_W'(r) * ARCP_W'(PI_Q29);
        p = (p << FRAC_BITS) + (ARCP_W'(1) << 28);
        return p[29 +: ARC_W];
    endfunction

    function automatic logic [Z_W-1:0] atan_turn(input int i);
        logic [Z_W-1:0] a;
        case (i)
            0:       a = 17'd8192;
            1:       a = 17'd4836;
            2:       a = 17'd2555;
            3:       a = 17'd1297;
            4:       a = 17'd651;
            5:       a = 17'd326;
            6:       a = 17'd163;
            7:       a = 17'd81;
            8:       a = 17'd41;
            9:       a = 17'd20;
            10:      a = 17'd10;
            11:      a = 17'd5;
            12:      a = 17'd3;
            default: a = 17'd1;
        endcase
        return a;
    endfunction

endpackage

// ===== design/stp_front.sv =====
// Front stages: lap to arc position, segment pick and straight-segment point.
module stp_front import stp_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [LAP_W-1:0]         lap,
    input  logic signed [LANE_W-1:0] lane,
    input  cfg_t                     cfg,
    output logic                     out_valid,
    output logic [ARC_W-1:0]         sc,
    output side_t                    side
);

    logic [15:0]        lq;
    logic [14:0]        half;
    logic [14:0]        rq;
    logic [TOTAL_W-1:0] total;
    logic [TOTAL_W-1:0] b1;
    logic [TOTAL_W-1:0] b2;

    assign lq    = {cfg.straight_length, 4'd0};
    assign half  = {cfg.straight_length, 3'd0};
    assign rq    = {cfg.turn_radius, 4'd0};
    assign total = (TOTAL_W'(lq) << 1) + (TOTAL_W'(cfg.arc) << 1);
    assign b1    = TOTAL_W'(lq) + TOTAL_W'(cfg.arc);
    assign b2    = (TOTAL_W'(lq) << 1) + TOTAL_W'(cfg.arc);

    logic                     v1_reg, v2_reg, v3_reg, v4_reg;
    logic [LAP_W-1:0]         sh1_reg;
    logic signed [LANE_W-1:0] lane1_reg, lane2_reg, lane3_reg;
    logic [PROD_W-1:0]        prod2_reg;
    logic [TOTAL_W-1:0]       s3_reg;
    logic [ARC_W-1:0]         sc4_reg;
    side_t                    side4_reg;

    logic [S_W-1:0]     s_raw;
    logic [TOTAL_W-1:0] s_next;
    side_t              side_next;
    logic [ARC_W-1:0]   sc_next;
    logic [POS_W-1:0]   base_x;
    logic [POS_W-1:0]   ry;

    assign s_raw  = S_W'(prod2_reg[PROD_W-1:ANGLE_BITS]) + S_W'(half);
    assign s_next = (s_raw >= S_W'(total)) ? TOTAL_W'(s_raw - S_W'(total)) : TOTAL_W'(s_raw);

    assign base_x = POS_W'({cfg.center_x, 4'd0}) + POS_W'(half);
    assign ry     = POS_W'(rq) + POS_W'(lane3_reg);

    always_comb begin
        side_next.rad  = RADQ_W'(signed'({2'b00, rq})) + RADQ_W'(lane3_reg);
        side_next.crad = FLAT_W'(cfg.turn_radius);
        side_next.px   = '0;
        side_next.py   = '0;
        sc_next        = '0;
        priority if (s3_reg < TOTAL_W'(lq)) begin
            side_next.seg  = SEG_BOTTOM;
            side_next.px   = base_x - POS_W'(s3_reg);
            side_next.py   = POS_W'({cfg.center_y, 4'd0}) + ry;
            side_next.crad = cfg.flat_radius;
        end else if (s3_reg < b1) begin
            side_next.seg = SEG_LEFT;
            sc_next       = ARC_W'(s3_reg - TOTAL_W'(lq));
        end else if (s3_reg < b2) begin
            side_next.seg  = SEG_TOP;
            side_next.px   = base_x + POS_W'(s3_reg) - POS_W'(b2);
            side_next.py   = POS_W'({cfg.center_y, 4'd0}) - ry;
            side_next.crad = cfg.flat_radius;
        end else begin
            side_next.seg = SEG_RIGHT;
            sc_next       = ARC_W'(s3_reg - b2);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sh1_reg   <= lap + LAP_SHIFT;
            lane1_reg <= lane;
            prod2_reg <= PROD_W'(sh1_reg) * PROD_W'(total);
            lane2_reg <= lane1_reg;
            s3_reg    <= s_next;
            lane3_reg <= lane2_reg;
            sc4_reg   <= sc_next;
            side4_reg <= side_next;
        end
    end

    assign out_valid = v4_reg;
    assign sc        = sc4_reg;
    assign side      = side4_reg;

endmodule

// ===== design/stp_div.sv =====
// Pipelined restoring divider: turn angle = arc position * 2^15 / arc length.
module stp_div import stp_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic [ARC_W-1:0] arc,
    input  logic             in_valid,
    input  logic [ARC_W-1:0] sc,
    input  side_t            in_side,
    output logic             out_valid,
    output logic [PHI_W-1:0] phi,
    output side_t            out_side
);

    logic             v_reg    [PHI_W];
    logic [ARC_W-1:0] rem_reg  [PHI_W];
    logic [PHI_W-1:0] q_reg    [PHI_W];
    side_t            side_reg [PHI_W];

    for (genvar k = 0; k < PHI_W; k++) begin : g_step
        logic             pv;
        logic [ARC_W-1:0] prem;
        logic [PHI_W-1:0] pq;
        side_t            pside;
        logic [ARC_W:0]   r2;
        logic             ge;

        if (k == 0) begin : g_first
            assign pv    = in_valid;
            assign prem  = sc;
            assign pq    = '0;
            assign pside = in_side;
        end else begin : g_rest
            assign pv    = v_reg[k-1];
            assign prem  = rem_reg[k-1];
            assign pq    = q_reg[k-1];
            assign pside = side_reg[k-1];
        end

        assign r2 = {prem, 1'b0};
        assign ge = (r2 >= {1'b0, arc});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= pv;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge ? ARC_W'(r2 - {1'b0, arc}) : ARC_W'(r2);
                q_reg[k]    <= {pq[PHI_W-2:0], ge};
                side_reg[k] <= pside;
            end
        end
    end

    // Zero arc length only happens at a zero turn radius: angle zero.
    assign out_valid = v_reg[PHI_W-1];
    assign phi       = (arc == '0) ? '0 : q_reg[PHI_W-1];
    assign out_side  = side_reg[PHI_W-1];

endmodule

// ===== design/stp_cordic.sv =====
// Pipelined rotation CORDIC, one micro-rotation per stage, on the first quadrant angle.
module stp_cordic import stp_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [PHI_W-1:0]       in_phi,
    input  side_t                  in_side,
    output logic                   out_valid,
    output logic signed [XY_W-1:0] x,
    output logic signed [XY_W-1:0] y,
    output logic [PHI_W-1:0]       out_phi,
    output side_t                  out_side
);

    logic                   v_reg    [CORDIC_STEPS];
    logic signed [XY_W-1:0] x_reg    [CORDIC_STEPS];
    logic signed [XY_W-1:0] y_reg    [CORDIC_STEPS];
    logic signed [Z_W-1:0]  z_reg    [CORDIC_STEPS];
    logic [PHI_W-1:0]       phi_reg  [CORDIC_STEPS];
    side_t                  side_reg [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
        logic                   pv;
        logic signed [XY_W-1:0] px;
        logic signed [XY_W-1:0] py;
        logic signed [Z_W-1:0]  pz;
        logic [PHI_W-1:0]       pphi;
        side_t                  pside;
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;
        logic signed [Z_W-1:0]  at;

        if (i == 0) begin : g_first
            assign pv    = in_valid;
            assign px    = signed'(CORDIC_GAIN);
            assign py    = '0;
            assign pz    = signed'(Z_W'(in_phi[PHI_W-2:0]));
            assign pphi  = in_phi;
            assign pside = in_side;
        end else begin : g_rest
            assign pv    = v_reg[i-1];
            assign px    = x_reg[i-1];
            assign py    = y_reg[i-1];
            assign pz    = z_reg[i-1];
            assign pphi  = phi_reg[i-1];
            assign pside = side_reg[i-1];
        end

        assign dx = py >>> i;
        assign dy = px >>> i;
        assign at = signed'(atan_turn(i));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (en) begin
                v_reg[i] <= pv;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (pz >= 0) begin
                    x_reg[i] <= px - dx;
                    y_reg[i] <= py + dy;
                    z_reg[i] <= pz - at;
                end else begin
                    x_reg[i] <= px + dx;
                    y_reg[i] <= py - dy;
                    z_reg[i] <= pz + at;
                end
                phi_reg[i]  <= pphi;
                side_reg[i] <= pside;
            end
        end
    end

    assign out_valid = v_reg[CORDIC_STEPS-1];
    assign x         = x_reg[CORDIC_STEPS-1];
    assign y         = y_reg[CORDIC_STEPS-1];
    assign out_phi   = phi_reg[CORDIC_STEPS-1];
    assign out_side  = side_reg[CORDIC_STEPS-1];

endmodule

// ===== design/stp_back.sv =====
// Back stages: quadrant fold, radius scaling and final point, heading and radius.
module stp_back import stp_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  cfg_t                   cfg,
    input  logic                   in_valid,
    input  logic signed [XY_W-1:0] x,
    input  logic signed [XY_W-1:0] y,
    input  logic [PHI_W-1:0]       phi,
    input  side_t                  in_side,
    output logic                   out_valid,
    output res_t                   res
);

    logic                      v1_reg, v2_reg, v3_reg;
    logic signed [XY_W-1:0]    sn1_reg, cs1_reg;
    logic [PHI_W-1:0]          phi1_reg, phi2_reg;
    side_t                     side1_reg, side2_reg;
    logic signed [SPROD_W-1:0] pa2_reg, pb2_reg;
    res_t                      res3_reg;

    logic signed [SPROD_W-1:0] pa_r;
    logic signed [SPROD_W-1:0] pb_r;
    logic [POS_W-1:0]          sa;
    logic [POS_W-1:0]          sb;
    logic [POS_W-1:0]          rcx;
    logic [POS_W-1:0]          lcx;
    logic [POS_W-1:0]          cy;
    res_t                      res_next;

    // Round half up, then floor shift by 16.
    assign pa_r = (pa2_reg + SPROD_W'(32768)) >>> 16;
    assign pb_r = (pb2_reg + SPROD_W'(32768)) >>> 16;
    assign sa   = POS_W'(pa_r);
    assign sb   = POS_W'(pb_r);
    assign rcx  = POS_W'({cfg.center_x, 4'd0}) + POS_W'({cfg.straight_length, 3'd0});
    assign lcx  = rcx - POS_W'({cfg.straight_length, 4'd0});
    assign cy   = POS_W'({cfg.center_y, 4'd0});

    always_comb begin
        res_next.seg  = side2_reg.seg;
        res_next.crad = side2_reg.crad;
        unique case (side2_reg.seg)
            SEG_BOTTOM: begin
                res_next.pos_x   = side2_reg.px;
                res_next.pos_y   = side2_reg.py;
                res_next.heading = HEAD_WEST;
            end
            SEG_LEFT: begin
                res_next.pos_x   = lcx - sa;
                res_next.pos_y   = cy + sb;
                res_next.heading = HEAD_WEST + HEAD_W'(phi2_reg);
            end
            SEG_TOP: begin
                res_next.pos_x   = side2_reg.px;
                res_next.pos_y   = side2_reg.py;
                res_next.heading = '0;
            end
            default: begin
                res_next.pos_x   = rcx + sa;
                res_next.pos_y   = cy - sb;
                res_next.heading = HEAD_W'(phi2_reg);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // Second quadrant when the angle passes a quarter turn.
            if (phi[PHI_W-1]) begin
                cs1_reg <= -y;
                sn1_reg <= x;
            end else begin
                cs1_reg <= x;
                sn1_reg <= y;
            end
            phi1_reg  <= phi;
            side1_reg <= in_side;
            pa2_reg   <= SPROD_W'(side1_reg.rad) * SPROD_W'(sn1_reg);
            pb2_reg   <= SPROD_W'(side1_reg.rad) * SPROD_W'(cs1_reg);
            phi2_reg  <= phi1_reg;
            side2_reg <= side1_reg;
            res3_reg  <= res_next;
        end
    end

    assign out_valid = v3_reg;
    assign res       = res3_reg;

endmodule

// ===== design/stadium_track_point.sv =====
// Stadium track point: lap fraction and lane offset to point, heading, segment, radius.
// Throughput: one word per cycle; the 15-stage divider and 14-stage CORDIC are fully
// pipelined; s_tready drops only while the one-word skid register holds a stalled word.
// Reset: synchronous, active low; clears all valid bits and loads register defaults.
// The derived arc length register is loaded together with turn_radius.
module stadium_track_point import stp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: [15:0] lap_fraction, [29:16] lane_offset, [31:30] zero
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // m_tdata: [17:0] pos_x, [35:18] pos_y, [51:36] heading, [67:52] curve_radius,
    //          [71:68] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,
    // m_tuser: [1:0] segment
    output logic [1:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers
    cfg_t     cfg_reg;
    reg_idx_t widx;
    logic     cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign widx   = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.turn_radius     <= RST_TURN_RADIUS;
            cfg_reg.straight_length <= RST_STRAIGHT_LENGTH;
            cfg_reg.center_x        <= RST_CENTER_X;
            cfg_reg.center_y        <= RST_CENTER_Y;
            cfg_reg.flat_radius     <= RST_FLAT_RADIUS;
            cfg_reg.arc             <= arc_of(RST_TURN_RADIUS);
        end else if (cfg_wr) begin
            // Drop writes to unmapped addresses.
            case (widx)
                REG_TURN_RADIUS: begin
                    cfg_reg.turn_radius <= pwdata[RAD_W-1:0];
                    cfg_reg.arc         <= arc_of(pwdata[RAD_W-1:0]);
                end
                REG_STRAIGHT_LENGTH: cfg_reg.straight_length <= pwdata[LEN_W-1:0];
                REG_CENTER_X:        cfg_reg.center_x        <= pwdata[CTR_W-1:0];
                REG_CENTER_Y:        cfg_reg.center_y        <= pwdata[CTR_W-1:0];
                REG_FLAT_RADIUS:     cfg_reg.flat_radius     <= pwdata[FLAT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (widx)
            REG_TURN_RADIUS:     prdata = 32'(cfg_reg.turn_radius);
            REG_STRAIGHT_LENGTH: prdata = 32'(cfg_reg.straight_length);
            REG_CENTER_X:        prdata = 32'(cfg_reg.center_x);
            REG_CENTER_Y:        prdata = 32'(cfg_reg.center_y);
            REG_FLAT_RADIUS:     prdata = 32'(cfg_reg.flat_radius);
            default:             prdata = '0;
        endcase
    end

    // Pipeline advances whenever the skid register is free.
    logic en;
    logic skid_v_reg;
    assign en       = !skid_v_reg;
    assign s_tready = en;

    logic                   f_valid;
    logic [ARC_W-1:0]       f_sc;
    side_t                  f_side;
    logic                   d_valid;
    logic [PHI_W-1:0]       d_phi;
    side_t                  d_side;
    logic                   c_valid;
    logic signed [XY_W-1:0] c_x;
    logic signed [XY_W-1:0] c_y;
    logic [PHI_W-1:0]       c_phi;
    side_t                  c_side;
    logic                   b_valid;
    res_t                   b_res;

    stp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .lap       (s_tdata[LAP_W-1:0]),
        .lane      (signed'(s_tdata[LAP_W +: LANE_W])),
        .cfg       (cfg_reg),
        .out_valid (f_valid),
        .sc        (f_sc),
        .side      (f_side)
    );

    stp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .arc       (cfg_reg.arc),
        .in_valid  (f_valid),
        .sc        (f_sc),
        .in_side   (f_side),
        .out_valid (d_valid),
        .phi       (d_phi),
        .out_side  (d_side)
    );

    stp_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d_valid),
        .in_phi    (d_phi),
        .in_side   (d_side),
        .out_valid (c_valid),
        .x         (c_x),
        .y         (c_y),
        .out_phi   (c_phi),
        .out_side  (c_side)
    );

    stp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (c_valid),
        .x         (c_x),
        .y         (c_y),
        .phi       (c_phi),
        .in_side   (c_side),
        .out_valid (b_valid),
        .res       (b_res)
    );

    // Output register with a one-word skid behind it.
    logic m_valid_reg;
    res_t out_reg;
    res_t skid_reg;
    logic hold;

    assign hold = m_valid_reg && !m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            skid_v_reg  <= 1'b0;
        end else begin
            if (skid_v_reg) begin
                if (!hold) begin
                    m_valid_reg <= 1'b1;
                    skid_v_reg  <= 1'b0;
                end
            end else if (b_valid) begin
                if (!hold) begin
                    m_valid_reg <= 1'b1;
                end else begin
                    skid_v_reg <= 1'b1;
                end
            end else if (!hold) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_v_reg) begin
            if (!hold) begin
                out_reg <= skid_reg;
            end
        end else if (b_valid) begin
            if (!hold) begin
                out_reg <= b_res;
            end else begin
                skid_reg <= b_res;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, out_reg.crad, out_reg.heading, out_reg.pos_y, out_reg.pos_x};
    assign m_tuser  = out_reg.seg;

endmodule

// ===== design/stp_checker.sv =====
// Port-level checker for the stadium track point, bound to the top level.
module stp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        pready
);

    localparam logic [1:0]  SEG_BOTTOM_C = 2'd0;
    localparam logic [1:0]  SEG_LEFT_C   = 2'd1;
    localparam logic [1:0]  SEG_TOP_C    = 2'd2;
    localparam logic [15:0] WEST         = 16'h8000;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_bottom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == SEG_BOTTOM_C) |-> m_tdata[51:36] == WEST)
        else $error("bottom straight heading wrong");

    a_top: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == SEG_TOP_C) |-> m_tdata[51:36] == 16'd0)
        else $error("top straight heading wrong");

    a_left: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == SEG_LEFT_C) |-> m_tdata[51])
        else $error("left turn heading outside its half turn");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && pready)
        else $error("result valid right after reset");

endmodule

bind stadium_track_point stp_checker u_stp_checker (.*);
